/* rtl/sss_pkg.sv */
// Shared types and constants for the SQL statement splitter.
// Used by sss_judge, sss_res_queue and sql_statement_splitter_core.
package sss_pkg;

	// Characters that drive the scan rules
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// Quote scope codes
	localparam logic [1:0] QS_OUT    = 2'd0;
	localparam logic [1:0] QS_SINGLE = 2'd1;
	localparam logic [1:0] QS_DOUBLE = 2'd2;

	// Comment scope codes
	localparam logic [1:0] CS_NONE  = 2'd0;
	localparam logic [1:0] CS_LINE  = 2'd1;
	localparam logic [1:0] CS_BLOCK = 2'd2;

	// Results one item can cause: two judged bytes and a status
	localparam int RES_DEPTH = 3;
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Scan state carried from byte to byte
	typedef struct packed {
		logic [7:0] prev_byte;
		logic       prev_valid;
		logic [1:0] quote;
		logic [1:0] comment;
		logic       tail_nonblank;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		prev_byte:     8'h00,
		prev_valid:    1'b0,
		quote:         QS_OUT,
		comment:       CS_NONE,
		tail_nonblank: 1'b0
	};

	// One result item
	typedef struct packed {
		logic       has_byte;
		logic [7:0] out_byte;
		logic       statement_end;
		logic       script_end;
		logic       tail_kept;
		logic       open_quote_error;
		logic       run_last;
	} res_t;

endpackage

/* rtl/sss_judge.sv */
// Judges one script byte against the scan state and a one-byte lookahead.
// Purely combinational; depends on sss_pkg.
module sss_judge (
	input  sss_pkg::scan_t st_in,
	input  logic [7:0]     c,
	input  logic           nx_valid,
	input  logic [7:0]     nx,
	output sss_pkg::scan_t st_out,
	output logic           emit,
	output sss_pkg::res_t  res
);

	logic       star_prev;
	logic       bslash_prev;
	logic [1:0] qn;

	assign star_prev   = st_in.prev_valid && (st_in.prev_byte == sss_pkg::CH_STAR);
	assign bslash_prev = st_in.prev_valid && (st_in.prev_byte == sss_pkg::CH_BSLASH);

	// Rules in priority order: newline, comment close/open, drop, dash-dash, quotes
	always_comb begin
		st_out            = st_in;
		st_out.prev_byte  = c;
		st_out.prev_valid = 1'b1;
		emit              = 1'b0;
		qn                = st_in.quote;
		res               = '0;
		res.has_byte      = 1'b1;
		res.out_byte      = c;
		if (c == sss_pkg::CH_CR || c == sss_pkg::CH_LF) begin
			if (st_in.comment == sss_pkg::CS_LINE) begin
				st_out.comment = sss_pkg::CS_NONE;
			end
			if (c == sss_pkg::CH_LF) begin
				emit         = 1'b1;
				res.out_byte = sss_pkg::CH_SPACE;
			end
		end else if (c == sss_pkg::CH_SLASH && st_in.comment == sss_pkg::CS_BLOCK
				&& star_prev) begin
			st_out.comment = sss_pkg::CS_NONE;
		end else if (c == sss_pkg::CH_SLASH && nx_valid && st_in.quote == sss_pkg::QS_OUT
				&& nx == sss_pkg::CH_STAR) begin
			st_out.comment = sss_pkg::CS_BLOCK;
		end else if (st_in.comment != sss_pkg::CS_NONE) begin
			// inside a comment: dropped
		end else if (c == sss_pkg::CH_DASH && nx_valid && st_in.quote == sss_pkg::QS_OUT
				&& nx == sss_pkg::CH_DASH) begin
			st_out.comment = sss_pkg::CS_LINE;
		end else begin
			// quote scope tracking, escaped close keeps the scope
			if (c == sss_pkg::CH_SQUOTE) begin
				if (st_in.quote == sss_pkg::QS_OUT) begin
					qn = sss_pkg::QS_SINGLE;
				end else if (st_in.quote == sss_pkg::QS_SINGLE && !bslash_prev) begin
					qn = sss_pkg::QS_OUT;
				end
			end else if (c == sss_pkg::CH_DQUOTE) begin
				if (st_in.quote == sss_pkg::QS_OUT) begin
					qn = sss_pkg::QS_DOUBLE;
				end else if (st_in.quote == sss_pkg::QS_DOUBLE && !bslash_prev) begin
					qn = sss_pkg::QS_OUT;
				end
			end
			st_out.quote = qn;
			res.statement_end = (c == sss_pkg::CH_SEMI) && (qn == sss_pkg::QS_OUT);
			if (res.statement_end) begin
				st_out.tail_nonblank = 1'b0;
			end else if (c != sss_pkg::CH_SPACE && c != sss_pkg::CH_TAB) begin
				st_out.tail_nonblank = 1'b1;
			end
			emit = 1'b1;
		end
	end

endmodule

/* rtl/sss_res_queue.sv */
// Result queue: takes up to three results of one item, hands them out in order.
// Depends on sss_pkg.
module sss_res_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ld,
	input  logic [sss_pkg::RES_DEPTH-1:0] ld_vld,
	input  sss_pkg::res_t ld_res [sss_pkg::RES_DEPTH],
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output sss_pkg::res_t out_res
);

	sss_pkg::res_t                 ents_q [sss_pkg::RES_DEPTH];
	sss_pkg::res_t                 ld_ents [sss_pkg::RES_DEPTH];
	logic [sss_pkg::RES_CNT_W-1:0] count_q;
	logic [sss_pkg::RES_CNT_W-1:0] ld_cnt;
	logic                          pop;

	assign out_valid = (count_q != '0);
	assign out_res   = ents_q[0];
	assign pop       = out_valid && out_ready;
	assign free      = (count_q == '0)
		|| (count_q == sss_pkg::RES_CNT_W'(1) && pop);

	// Pack the valid results to the front
	always_comb begin
		ld_ents = ents_q;
		ld_cnt  = '0;
		for (int i = 0; i < sss_pkg::RES_DEPTH; i++) begin
			if (ld_vld[i]) begin
				ld_ents[ld_cnt[$clog2(sss_pkg::RES_DEPTH)-1:0]] = ld_res[i];
				ld_cnt = ld_cnt + 1'b1;
			end
		end
	end

	// Fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ld) begin
			count_q <= ld_cnt;
		end else if (pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Entries: load whole, shift down on each handout
	always_ff @(posedge clk) begin
		if (ld) begin
			ents_q <= ld_ents;
		end else if (pop) begin
			for (int i = 0; i < sss_pkg::RES_DEPTH - 1; i++) begin
				ents_q[i] <= ents_q[i+1];
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sss_pkg::RES_CNT_W'(sss_pkg::RES_DEPTH))
		else $error("result queue over-full");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> free)
		else $error("result queue loaded while holding undelivered results");

endmodule

/* rtl/sql_statement_splitter_core.sv */
// SQL statement splitter top: input register, byte judge, result queue.
// Order: the results of an item are registered in the result queue when it leaves
// the input register; a byte is judged when the next byte (its lookahead) arrives.
// Throughput: one item per cycle while m accepts each result; a final item yields
// up to three, handed out one per cycle by the result queue, stalling input meanwhile.
// Reset (arst_n low, asynchronous): scan state, input and queue valids cleared.
module sql_statement_splitter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] statement_end,
	                               // [9] tail_kept, [10] open_quote_error
	output logic [1:0]  m_tuser,   // [0] has_byte, [1] script_end
	output logic        m_tlast    // run_last
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Scan state
	logic           held_valid_q;
	logic [7:0]     held_byte_q;
	sss_pkg::scan_t st_q;

	sss_pkg::scan_t st_a, st_b;
	sss_pkg::scan_t j0_st, j1_st;
	logic           j0_emit, j1_emit;
	sss_pkg::res_t  j0_res, j1_res;

	logic                          q_free;
	logic                          xfer;
	logic [sss_pkg::RES_DEPTH-1:0] ld_vld;
	sss_pkg::res_t                 ld_res [sss_pkg::RES_DEPTH];
	sss_pkg::res_t                 out_res;

	assign xfer     = valid_s1 && q_free;
	assign s_tready = !valid_s1 || xfer;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Held byte, judged with the incoming byte as lookahead
	sss_judge u_judge_held (
		.st_in    (st_q),
		.c        (held_byte_q),
		.nx_valid (1'b1),
		.nx       (byte_s1),
		.st_out   (j0_st),
		.emit     (j0_emit),
		.res      (j0_res)
	);

	assign st_a = held_valid_q ? j0_st : st_q;

	// Final byte, judged with no lookahead
	sss_judge u_judge_last (
		.st_in    (st_a),
		.c        (byte_s1),
		.nx_valid (1'b0),
		.nx       (8'h00),
		.st_out   (j1_st),
		.emit     (j1_emit),
		.res      (j1_res)
	);

	assign st_b = j1_st;

	// Result set of the item in the input register
	always_comb begin
		ld_vld[0] = held_valid_q && j0_emit;
		ld_vld[1] = last_s1 && j1_emit;
		ld_vld[2] = last_s1;
		ld_res[0] = j0_res;
		ld_res[0].run_last = !last_s1;
		ld_res[1] = j1_res;
		ld_res[2] = '0;
		ld_res[2].script_end       = 1'b1;
		ld_res[2].tail_kept        = st_b.tail_nonblank;
		ld_res[2].open_quote_error = (st_b.quote != sss_pkg::QS_OUT);
		ld_res[2].run_last         = 1'b1;
	end

	// Scan state update; a final byte returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_byte_q  <= 8'h00;
			st_q         <= sss_pkg::SCAN_RESET;
		end else if (xfer) begin
			if (last_s1) begin
				held_valid_q <= 1'b0;
				held_byte_q  <= 8'h00;
				st_q         <= sss_pkg::SCAN_RESET;
			end else begin
				held_valid_q <= 1'b1;
				held_byte_q  <= byte_s1;
				st_q         <= st_a;
			end
		end
	end

	sss_res_queue u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (xfer),
		.ld_vld    (ld_vld),
		.ld_res    (ld_res),
		.free      (q_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Output packing
	assign m_tdata = {5'b0, out_res.open_quote_error, out_res.tail_kept,
		out_res.statement_end, out_res.out_byte};
	assign m_tuser = {out_res.script_end, out_res.has_byte};
	assign m_tlast = out_res.run_last;

	a_status_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("status result not last of its run or carries a byte");

	a_final_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && last_s1 |=> !held_valid_q && st_q == sss_pkg::SCAN_RESET)
		else $error("scan state not cleared after final byte");

	a_nonfinal_holds: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !last_s1 |=> held_valid_q && held_byte_q == $past(byte_s1))
		else $error("byte not held for lookahead");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input register");

endmodule

/* tb/sv/tb_sql_statement_splitter_core.sv */
// Testbench for sql_statement_splitter_core: directed and random SQL scripts,
// each item predicted by a scan model kept here and checked at the m side.
// Depends on sss_pkg for the character codes, scope codes and the result struct.
module tb_sql_statement_splitter_core;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	sql_statement_splitter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int errors         = 0;

	// Results predicted for accepted items, oldest first
	sss_pkg::res_t predicted_out[$];
	// Bytes of the script being built
	logic [7:0] script_buf[$];

	// Scan state of the predictor
	logic [7:0] lk_held;
	bit         lk_held_v;
	logic [7:0] sc_prev;
	bit         sc_prev_v;
	logic [1:0] sc_quote;
	logic [1:0] sc_comment;
	bit         sc_tail;

	function automatic void clear_scan();
		lk_held    = 8'h00;
		lk_held_v  = 1'b0;
		sc_prev    = 8'h00;
		sc_prev_v  = 1'b0;
		sc_quote   = sss_pkg::QS_OUT;
		sc_comment = sss_pkg::CS_NONE;
		sc_tail    = 1'b0;
	endfunction

	// Judge one byte against its lookahead; returns 1 if it is emitted
	function automatic bit scan_byte(input logic [7:0] c, input bit nx_v,
	                                 input logic [7:0] nx, output sss_pkg::res_t r);
		bit         pv;
		logic [7:0] pb;
		bit         stmt_end;
		r  = '0;
		pv = sc_prev_v;
		pb = sc_prev;
		sc_prev   = c;
		sc_prev_v = 1'b1;
		if (c == sss_pkg::CH_CR || c == sss_pkg::CH_LF) begin
			if (sc_comment == sss_pkg::CS_LINE)
				sc_comment = sss_pkg::CS_NONE;
			if (c == sss_pkg::CH_LF) begin
				r.has_byte = 1'b1;
				r.out_byte = sss_pkg::CH_SPACE;
				return 1'b1;
			end
			return 1'b0;
		end
		// comment close and block comment open
		if (c == sss_pkg::CH_SLASH) begin
			if (sc_comment == sss_pkg::CS_BLOCK && pv && pb == sss_pkg::CH_STAR) begin
				sc_comment = sss_pkg::CS_NONE;
				return 1'b0;
			end
			if (nx_v && sc_quote == sss_pkg::QS_OUT && nx == sss_pkg::CH_STAR) begin
				sc_comment = sss_pkg::CS_BLOCK;
				return 1'b0;
			end
		end
		if (sc_comment != sss_pkg::CS_NONE)
			return 1'b0;
		if (c == sss_pkg::CH_DASH && nx_v && sc_quote == sss_pkg::QS_OUT
				&& nx == sss_pkg::CH_DASH) begin
			sc_comment = sss_pkg::CS_LINE;
			return 1'b0;
		end
		// quote scope, escaped close keeps it open
		if (c == sss_pkg::CH_SQUOTE) begin
			if (sc_quote == sss_pkg::QS_OUT)
				sc_quote = sss_pkg::QS_SINGLE;
			else if (sc_quote == sss_pkg::QS_SINGLE && !(pv && pb == sss_pkg::CH_BSLASH))
				sc_quote = sss_pkg::QS_OUT;
		end else if (c == sss_pkg::CH_DQUOTE) begin
			if (sc_quote == sss_pkg::QS_OUT)
				sc_quote = sss_pkg::QS_DOUBLE;
			else if (sc_quote == sss_pkg::QS_DOUBLE && !(pv && pb == sss_pkg::CH_BSLASH))
				sc_quote = sss_pkg::QS_OUT;
		end
		stmt_end = (c == sss_pkg::CH_SEMI && sc_quote == sss_pkg::QS_OUT);
		if (stmt_end)
			sc_tail = 1'b0;
		else if (c != sss_pkg::CH_SPACE && c != sss_pkg::CH_TAB)
			sc_tail = 1'b1;
		r.has_byte      = 1'b1;
		r.out_byte      = c;
		r.statement_end = stmt_end;
		return 1'b1;
	endfunction

	// Work out the results of one accepted item
	function automatic void predict_split(input logic [7:0] b, input logic last);
		sss_pkg::res_t rs[3];
		sss_pkg::res_t r;
		int            n;
		n = 0;
		if (lk_held_v) begin
			if (scan_byte(lk_held, 1'b1, b, r)) begin
				rs[n] = r;
				n++;
			end
		end
		if (!last) begin
			lk_held   = b;
			lk_held_v = 1'b1;
		end else begin
			if (scan_byte(b, 1'b0, 8'h00, r)) begin
				rs[n] = r;
				n++;
			end
			r = '0;
			r.script_end       = 1'b1;
			r.tail_kept        = sc_tail;
			r.open_quote_error = (sc_quote != sss_pkg::QS_OUT);
			rs[n] = r;
			n++;
			clear_scan();
		end
		if (n > 0)
			rs[n-1].run_last = 1'b1;
		for (int i = 0; i < n; i++)
			predicted_out = {predicted_out, rs[i]};
	endfunction

	function automatic void check_field(input string name, input logic [7:0] e,
	                                    input logic [7:0] a);
		if (a !== e) begin
			errors++;
			if (errors <= 10)
				$display("[%0t] result %0d: %s expected %0h, got %0h",
				         $realtime, results_seen, name, e, a);
		end
	endfunction

	// Compare one accepted result with the oldest prediction
	function automatic void check_result();
		sss_pkg::res_t e;
		if (predicted_out.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("[%0t] unexpected result: tdata %0h tuser %0h tlast %0b",
				         $realtime, m_tdata, m_tuser, m_tlast);
			return;
		end
		e = predicted_out.pop_front();
		check_field("has_byte",         8'(e.has_byte),         8'(m_tuser[0]));
		check_field("out_byte",         e.out_byte,             m_tdata[7:0]);
		check_field("statement_end",    8'(e.statement_end),    8'(m_tdata[8]));
		check_field("script_end",       8'(e.script_end),       8'(m_tuser[1]));
		check_field("tail_kept",        8'(e.tail_kept),        8'(m_tdata[9]));
		check_field("open_quote_error", 8'(e.open_quote_error), 8'(m_tdata[10]));
		check_field("run_last",         8'(e.run_last),         8'(m_tlast));
		results_seen++;
	endfunction

	// Predict on accepted items, check accepted results
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predict_split(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			check_result();
	end

	// Receiver stalls
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Send one item; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string txt, input bit close_script);
		for (int i = 0; i < txt.len(); i++)
			send_byte(txt[i], close_script && (i == txt.len() - 1));
	endtask

	// A byte that tends to trigger a scan rule
	function automatic logic [7:0] rule_char();
		case ($urandom_range(0, 11))
			0:       return sss_pkg::CH_SLASH;
			1:       return sss_pkg::CH_STAR;
			2:       return sss_pkg::CH_DASH;
			3:       return sss_pkg::CH_SQUOTE;
			4:       return sss_pkg::CH_DQUOTE;
			5:       return sss_pkg::CH_BSLASH;
			6:       return sss_pkg::CH_SEMI;
			7:       return sss_pkg::CH_LF;
			8:       return sss_pkg::CH_CR;
			9:       return sss_pkg::CH_SPACE;
			10:      return sss_pkg::CH_TAB;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] body_char();
		if ($urandom_range(0, 1) == 0)
			return 8'h61 + 8'($urandom_range(0, 25));
		return rule_char();
	endfunction

	// Add one byte to the end of the script being built
	function automatic void append_char(input logic [7:0] ch);
		script_buf = {script_buf, ch};
	endfunction

	// Append one token: mostly well formed, some broken or noise
	function automatic void add_token();
		logic [7:0] q;
		case ($urandom_range(0, 9))
			0, 1: begin
				repeat ($urandom_range(1, 4))
					append_char(8'h61 + 8'($urandom_range(0, 25)));
			end
			2: begin
				q = $urandom_range(0, 1) ? sss_pkg::CH_SQUOTE : sss_pkg::CH_DQUOTE;
				append_char(q);
				repeat ($urandom_range(0, 4))
					append_char(body_char());
				if ($urandom_range(0, 4) != 0)
					append_char(q);
			end
			3: begin
				append_char(sss_pkg::CH_DASH);
				append_char(sss_pkg::CH_DASH);
				repeat ($urandom_range(0, 3))
					append_char(body_char());
				if ($urandom_range(0, 3) != 0)
					append_char(sss_pkg::CH_LF);
			end
			4: begin
				append_char(sss_pkg::CH_SLASH);
				append_char(sss_pkg::CH_STAR);
				repeat ($urandom_range(0, 3))
					append_char(body_char());
				if ($urandom_range(0, 3) != 0) begin
					append_char(sss_pkg::CH_STAR);
					append_char(sss_pkg::CH_SLASH);
				end
			end
			5, 6:    append_char(sss_pkg::CH_SEMI);
			7: begin
				case ($urandom_range(0, 3))
					0:       append_char(sss_pkg::CH_SPACE);
					1:       append_char(sss_pkg::CH_TAB);
					2:       append_char(sss_pkg::CH_CR);
					default: append_char(sss_pkg::CH_LF);
				endcase
			end
			8:       append_char(rule_char());
			default: append_char(8'($urandom_range(0, 255)));
		endcase
	endfunction

	// Random scripts until the phase has sent its share of items
	task automatic send_random_scripts(input int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			script_buf.delete();
			repeat ($urandom_range(1, 8))
				add_token();
			for (int i = 0; i < script_buf.size(); i++)
				send_byte(script_buf[i], i == script_buf.size() - 1);
		end
	endtask

	// Comments, line and block, both quotes, escapes, extremes, short scripts
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_text("a/*;*/", 1'b0);
		send_byte(sss_pkg::CH_CR, 1'b0);
		// line comment turning into a block comment, LF inside it
		send_text("--/*\n*/", 1'b0);
		// escaped quote, other quote and semicolon inside single quotes
		send_text("'\\'\";'", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(sss_pkg::CH_SEMI, 1'b0);
		send_byte(8'h00, 1'b0);
		// open double quote, final slash has no lookahead
		send_text("\"/", 1'b1);
		// one-byte script
		send_byte(sss_pkg::CH_DASH, 1'b1);
	endtask

	task automatic test_no_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_random_scripts(48);
	endtask

	task automatic test_sender_idle();
		send_idle_pct  = 67;
		recv_stall_pct = 0;
		send_random_scripts(48);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct  = 0;
		recv_stall_pct = 67;
		send_random_scripts(48);
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		send_random_scripts(48);
	endtask

	initial begin
		int waited;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tlast  = 1'b0;
		m_tready = 1'b0;
		clear_scan();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		s_tvalid <= 1'b0;

		// drain the remaining results, then let the pipeline settle
		waited = 0;
		while (predicted_out.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (predicted_out.size() != 0) begin
			$display("%0d predicted results never arrived", predicted_out.size());
			errors += predicted_out.size();
		end

		if (errors == 0) begin
			$display("** sql_statement_splitter_core: PASSED **");
		end else begin
			$display("** sql_statement_splitter_core: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("timeout waiting for the splitter");
		$display("** sql_statement_splitter_core: FAILED **");
		$finish;
	end

endmodule

/* sql_statement_splitter_core.f */
rtl/sss_pkg.sv
rtl/sss_judge.sv
rtl/sss_res_queue.sv
rtl/sql_statement_splitter_core.sv
tb/sv/tb_sql_statement_splitter_core.sv
